// ===== hw/rtl/fltc_pkg.sv =====
// Shared types and constants for the flow tuple counter.
`timescale 1ns / 1ps
package fltc_pkg;
  localparam int FLOW_ENTRIES = 1024;
  localparam int IDX_W        = $clog2(FLOW_ENTRIES);
  localparam int USED_W       = IDX_W + 1;

  localparam logic [13:0] POS_MAX   = 14'd16383;
  localparam logic [14:0] COUNT_MAX = 15'd32767;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_COUNTED = 3'd1;
  localparam logic [2:0] ST_BAD_LEN = 3'd2;
  localparam logic [2:0] ST_NOT_IP  = 3'd3;
  localparam logic [2:0] ST_NOT_L4  = 3'd4;
  localparam logic [2:0] ST_TRUNC   = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  localparam logic [1:0] REG_COUNT_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_LEN     = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [63:0] addr;
    logic [7:0]  proto;
    logic [15:0] port;
  } fltc_req_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [14:0] count;
  } fltc_entry_t;
endpackage

// ===== hw/rtl/fltc_parser.sv =====
// Byte-wise header capture and frame pre-checks.
`timescale 1ns / 1ps
module fltc_parser import fltc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  frame_byte,
  input  logic        end_of_frame,
  input  logic [13:0] min_len,
  input  logic [13:0] max_len,
  output fltc_req_t   req
);
  logic [13:0] pos_r, pos_nxt;
  logic [15:0] et_r, et_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] port_r, port_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [13:0] port_at;
  logic [14:0] len;
  logic [2:0]  status;

  always_comb begin
    port_at   = 14'd16 + {8'd0, ihl_r, 2'b00};
    et_nxt    = et_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    port_nxt  = port_r;
    addr_nxt  = addr_r;
    if (pos_r == 14'd12 || pos_r == 14'd13) et_nxt = {et_r[7:0], frame_byte};
    if (pos_r == 14'd14) ihl_nxt = frame_byte[3:0];
    if (pos_r == 14'd23) proto_nxt = frame_byte;
    if (pos_r >= 14'd26 && pos_r <= 14'd33) addr_nxt = {addr_r[55:0], frame_byte};
    if (pos_r == port_at) port_nxt[15:8] = frame_byte;
    if (pos_r == port_at + 14'd1) port_nxt[7:0] = frame_byte;
    pos_nxt = (pos_r < POS_MAX) ? pos_r + 14'd1 : pos_r;
  end

  always_comb begin
    len = {1'b0, pos_r} + 15'd1;
    if (len < {1'b0, min_len} || len > {1'b0, max_len}) status = ST_BAD_LEN;
    else if (len < 15'd14) status = ST_TRUNC;
    else if (et_nxt != ETYPE_IPV4) status = ST_NOT_IP;
    else if (len < 15'd24) status = ST_TRUNC;
    else if (proto_nxt != PROTO_TCP && proto_nxt != PROTO_UDP) status = ST_NOT_L4;
    else if (len < 15'd34 || len < 15'd18 + {9'd0, ihl_nxt, 2'b00}) status = ST_TRUNC;
    else status = ST_NEW;  // goes to the table lookup
    req.valid  = accept && end_of_frame;
    req.status = status;
    req.addr   = addr_nxt;
    req.proto  = proto_nxt;
    req.port   = port_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && end_of_frame)) begin
      pos_r   <= '0;
      et_r    <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      port_r  <= '0;
      addr_r  <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      et_r    <= et_nxt;
      ihl_r   <= ihl_nxt;
      proto_r <= proto_nxt;
      port_r  <= port_nxt;
      addr_r  <= addr_nxt;
    end
  end
endmodule

// ===== hw/rtl/fltc_table.sv =====
// Flow table memory with linear search, insert and count update.
`timescale 1ns / 1ps
module fltc_table import fltc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fltc_req_t   req,
  input  logic [14:0] count_limit,
  output logic        busy,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_flow_index,
  output logic [14:0] out_packet_count,
  output logic [7:0]  out_protocol,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_dest_port
);
  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  fltc_entry_t mem [FLOW_ENTRIES];
  fltc_entry_t rd_data_r;
  state_t      state_r;
  logic [USED_W-1:0] used_r, scan_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic [63:0] key_addr_r;
  logic [7:0]  key_proto_r;
  logic [15:0] key_port_r;
  logic        hit, scan_done, rd_en, wr_en;
  logic [IDX_W-1:0] wr_addr;
  fltc_entry_t wr_data;
  logic [14:0] cnt_nxt;

  always_comb begin
    hit = pend_r && rd_data_r.addr == key_addr_r && rd_data_r.proto == key_proto_r
          && rd_data_r.port == key_port_r;
    scan_done = (scan_r == used_r) && !pend_r;
    rd_en = (state_r == S_SEARCH) && !hit && (scan_r != used_r);
    cnt_nxt = (rd_data_r.count <= count_limit && rd_data_r.count < COUNT_MAX) ?
              rd_data_r.count + 15'd1 : rd_data_r.count;
    wr_en   = 1'b0;
    wr_addr = pend_idx_r;
    wr_data = '{addr: key_addr_r, proto: key_proto_r, port: key_port_r, count: cnt_nxt};
    if (state_r == S_SEARCH) begin
      if (hit) begin
        wr_en = 1'b1;
      end else if (scan_done && used_r != USED_W'(FLOW_ENTRIES)) begin
        wr_en         = 1'b1;
        wr_addr       = used_r[IDX_W-1:0];
        wr_data.count = 15'd1;
      end
    end
    busy = (state_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[scan_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      scan_r    <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.valid) begin
            key_addr_r         <= req.addr;
            key_proto_r        <= req.proto;
            key_port_r         <= req.port;
            out_protocol       <= req.proto;
            out_source_address <= req.addr[63:32];
            out_dest_address   <= req.addr[31:0];
            out_dest_port      <= req.port;
            if (req.status == ST_NEW) begin
              state_r <= S_SEARCH;
              scan_r  <= '0;
              pend_r  <= 1'b0;
            end else begin
              out_valid        <= 1'b1;
              out_status       <= req.status;
              out_flow_index   <= '0;
              out_packet_count <= '0;
            end
          end
        end
        S_SEARCH: begin
          pend_r     <= rd_en;
          pend_idx_r <= scan_r[IDX_W-1:0];
          if (rd_en) scan_r <= scan_r + USED_W'(1);
          if (hit) begin
            state_r          <= S_IDLE;
            out_valid        <= 1'b1;
            out_status       <= ST_COUNTED;
            out_flow_index   <= 10'(pend_idx_r);
            out_packet_count <= cnt_nxt;
          end else if (scan_done) begin
            state_r   <= S_IDLE;
            out_valid <= 1'b1;
            if (used_r == USED_W'(FLOW_ENTRIES)) begin
              out_status       <= ST_FULL;
              out_flow_index   <= '0;
              out_packet_count <= '0;
            end else begin
              used_r           <= used_r + USED_W'(1);
              out_status       <= ST_NEW;
              out_flow_index   <= 10'(used_r);
              out_packet_count <= 15'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(FLOW_ENTRIES)) else $error("fill count above table size");
  a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.valid && state_r != S_IDLE)) else $error("request while searching");
  a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NEW) |-> used_r == $past(used_r) + USED_W'(1))
    else $error("new flow without fill count step");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= used_r) else $error("scan beyond filled entries");
endmodule

// ===== hw/rtl/flow_tuple_counter.sv =====
// Top level of the IPv4 flow tuple counter.
`timescale 1ns / 1ps
//  channel | ports                                   | handshake
//  in      | in_frame_byte, in_end_of_frame          | start & !busy
//  out     | out_status .. out_dest_port             | out_valid strobe, 1 cycle
//  cfg     | cfg_we, cfg_index, cfg_wdata            | cfg_we, no wait
//
//  A byte is taken per cycle while start is high and busy is low. The last
//  byte of a frame that passes the checks raises busy for the flow table
//  search: one entry read per cycle from the table memory, up to the flows
//  in use; the last byte of a rejected frame leaves busy low.
//  The result strobe comes in the cycle after the lookup ends; the receiver
//  cannot stall it. Reset (sync, active low) empties the table via the fill
//  count at once, with no clearing pass.
module flow_tuple_counter import fltc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_end_of_frame,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_flow_index,
  output logic [14:0] out_packet_count,
  output logic [7:0]  out_protocol,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_dest_port,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  logic [14:0] count_limit_r;
  logic [13:0] min_len_r, max_len_r;
  logic        accept;
  fltc_req_t   req;

  assign accept = start && !busy;

  // configuration registers, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r <= 15'd10000;
      min_len_r     <= 14'd64;
      max_len_r     <= 14'd1518;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_LIMIT: count_limit_r <= cfg_wdata;
        REG_MIN_LEN:     min_len_r     <= cfg_wdata[13:0];
        REG_MAX_LEN:     max_len_r     <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  fltc_parser u_parser (
    .clk, .rst_n, .accept,
    .frame_byte   (in_frame_byte),
    .end_of_frame (in_end_of_frame),
    .min_len      (min_len_r),
    .max_len      (max_len_r),
    .req
  );

  fltc_table u_table (
    .clk, .rst_n, .req,
    .count_limit (count_limit_r),
    .busy, .out_valid, .out_status, .out_flow_index, .out_packet_count,
    .out_protocol, .out_source_address, .out_dest_address, .out_dest_port
  );
endmodule
